@@ hdl/spk_pkg.sv @@
// ----------------------------------------------------------------------------
// spk_pkg
// Shared constants, types and round functions for the Speck128/128 cipher.
// ----------------------------------------------------------------------------
package spk_pkg;

  localparam int NUM_ROUNDS = 32;
  localparam int WORD_W     = 64;
  localparam int ROT_A      = 8;
  localparam int ROT_B      = 3;
  localparam int RK_IDX_W   = (NUM_ROUNDS > 1) ? $clog2(NUM_ROUNDS) : 1;
  localparam int CFG_IDX_W  = 8;

  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [RK_IDX_W-1:0]  rk_idx_t;

  localparam cfg_idx_t REG_KEY_LOW  = cfg_idx_t'(0);
  localparam cfg_idx_t REG_KEY_HIGH = cfg_idx_t'(1);

  typedef enum logic {
    OP_ENC = 1'b0,
    OP_DEC = 1'b1
  } op_t;

  typedef struct packed {
    word_t x;
    word_t y;
  } pair_t;

  typedef struct packed {
    logic  op;
    word_t x;
    word_t y;
  } blk_t;

  function automatic word_t ror_a(input word_t v);
    return {v[ROT_A-1:0], v[WORD_W-1:ROT_A]};
  endfunction

  function automatic word_t rol_a(input word_t v);
    return {v[WORD_W-ROT_A-1:0], v[WORD_W-1:WORD_W-ROT_A]};
  endfunction

  function automatic word_t ror_b(input word_t v);
    return {v[ROT_B-1:0], v[WORD_W-1:ROT_B]};
  endfunction

  function automatic word_t rol_b(input word_t v);
    return {v[WORD_W-ROT_B-1:0], v[WORD_W-1:WORD_W-ROT_B]};
  endfunction

  function automatic pair_t fwd_round(input word_t x, input word_t y, input word_t k);
    pair_t r;
    r.x = (ror_a(x) + y) ^ k;
    r.y = rol_b(y) ^ r.x;
    return r;
  endfunction

  function automatic pair_t inv_round(input word_t x, input word_t y, input word_t k);
    pair_t r;
    r.y = ror_b(y ^ x);
    r.x = rol_a((x ^ k) - r.y);
    return r;
  endfunction

endpackage

@@ hdl/spk_if.sv @@
// ----------------------------------------------------------------------------
// spk_in_if / spk_out_if
// Valid/ready channels carrying plaintext or ciphertext blocks and results.
// ----------------------------------------------------------------------------
interface spk_in_if;
  logic                valid;
  logic                ready;
  logic                op;
  spk_pkg::word_t      block_low;
  spk_pkg::word_t      block_high;

  modport source (output valid, op, block_low, block_high, input ready);
  modport sink   (input valid, op, block_low, block_high, output ready);
endinterface

interface spk_out_if;
  logic                valid;
  logic                ready;
  spk_pkg::word_t      result_low;
  spk_pkg::word_t      result_high;

  modport source (output valid, result_low, result_high, input ready);
  modport sink   (input valid, result_low, result_high, output ready);
endinterface

@@ hdl/spk_key_sched.sv @@
// ----------------------------------------------------------------------------
// spk_key_sched
// Key registers and iterative round key expansion, one key per cycle.
// ----------------------------------------------------------------------------
module spk_key_sched (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  spk_pkg::cfg_idx_t     wr_index,
  input  spk_pkg::word_t        wr_data,
  output logic                  busy,
  output spk_pkg::word_t        rk [spk_pkg::NUM_ROUNDS]
);

  localparam int      LAST_CNT = (spk_pkg::NUM_ROUNDS > 1) ? spk_pkg::NUM_ROUNDS - 2 : 0;
  localparam logic    EXPANDS  = (spk_pkg::NUM_ROUNDS > 1);

  spk_pkg::word_t  key_low;
  spk_pkg::word_t  key_high;
  spk_pkg::word_t  key_low_next;
  spk_pkg::word_t  key_high_next;
  logic            key_wr;
  spk_pkg::word_t  a;
  spk_pkg::word_t  b;
  spk_pkg::rk_idx_t cnt;
  spk_pkg::pair_t  step;

  always_comb begin
    key_low_next  = key_low;
    key_high_next = key_high;
    key_wr        = 1'b0;
    if (wr_en) begin
      unique case (wr_index)
        spk_pkg::REG_KEY_LOW: begin
          key_low_next = wr_data;
          key_wr       = 1'b1;
        end
        spk_pkg::REG_KEY_HIGH: begin
          key_high_next = wr_data;
          key_wr        = 1'b1;
        end
        default: begin
          key_wr = 1'b0;
        end
      endcase
    end
  end

  assign step = spk_pkg::fwd_round(a, b, spk_pkg::WORD_W'(cnt));

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
      a        <= '0;
      b        <= '0;
      cnt      <= '0;
      busy     <= EXPANDS;
    end else if (key_wr) begin
      key_low  <= key_low_next;
      key_high <= key_high_next;
      a        <= key_high_next;
      b        <= key_low_next;
      cnt      <= '0;
      busy     <= EXPANDS;
    end else if (busy) begin
      a   <= step.x;
      b   <= step.y;
      cnt <= cnt + 1'b1;
      if (cnt == spk_pkg::RK_IDX_W'(LAST_CNT)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rk[0] <= '0;
    end else if (key_wr) begin
      rk[0] <= key_low_next;
    end else if (busy) begin
      rk[cnt + 1'b1] <= step.y;
    end
  end

endmodule

@@ hdl/spk_stage.sv @@
// ----------------------------------------------------------------------------
// spk_stage
// One registered cipher round, forward or inverse as the item's op selects.
// ----------------------------------------------------------------------------
module spk_stage (
  input  logic            clk,
  input  logic            rst,
  input  spk_pkg::word_t  key_enc,
  input  spk_pkg::word_t  key_dec,
  input  logic            up_valid,
  input  spk_pkg::blk_t   up_item,
  output logic            up_ready,
  output logic            dn_valid,
  output spk_pkg::blk_t   dn_item,
  input  logic            dn_ready
);

  spk_pkg::pair_t res;

  assign up_ready = !dn_valid || dn_ready;

  always_comb begin
    if (up_item.op == spk_pkg::OP_DEC) begin
      res = spk_pkg::inv_round(up_item.x, up_item.y, key_dec);
    end else begin
      res = spk_pkg::fwd_round(up_item.x, up_item.y, key_enc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_item <= '{op: up_item.op, x: res.x, y: res.y};
    end
  end

endmodule

@@ hdl/speck128_block_cipher.sv @@
// ----------------------------------------------------------------------------
// speck128_block_cipher
// Speck128/128 block cipher engine, one round per pipeline stage.
// ----------------------------------------------------------------------------
// Each item passes NUM_ROUNDS (32) register stages, one round per stage, and a
// new item can be taken every cycle while the output does not stall and the
// keys are not being rebuilt; output stalls back up stage by stage. After reset
// and after every key register write the round key table is rebuilt by one
// shared round unit, one key per cycle; while it is rebuilt, input ready stays low.
module speck128_block_cipher (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  spk_pkg::cfg_idx_t  wr_index,
  input  spk_pkg::word_t     wr_data,
  spk_in_if.sink             blk_in,
  spk_out_if.source          blk_out
);

  localparam int N = spk_pkg::NUM_ROUNDS;

  logic            busy;
  spk_pkg::word_t  rk   [N];
  logic            v    [N+1];
  logic            rdy  [N+1];
  spk_pkg::blk_t   item [N+1];

  spk_key_sched u_key_sched (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .busy     (busy),
    .rk       (rk)
  );

  assign v[0]         = blk_in.valid && !busy;
  assign item[0]      = '{op: blk_in.op, x: blk_in.block_high, y: blk_in.block_low};
  assign blk_in.ready = rdy[0] && !busy;

  for (genvar i = 0; i < N; i++) begin : g_stage
    spk_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .key_enc  (rk[i]),
      .key_dec  (rk[N-1-i]),
      .up_valid (v[i]),
      .up_item  (item[i]),
      .up_ready (rdy[i]),
      .dn_valid (v[i+1]),
      .dn_item  (item[i+1]),
      .dn_ready (rdy[i+1])
    );
  end

  assign rdy[N]              = blk_out.ready;
  assign blk_out.valid       = v[N];
  assign blk_out.result_low  = item[N].y;
  assign blk_out.result_high = item[N].x;

endmodule

@@ hdl/spk_checker.sv @@
// ----------------------------------------------------------------------------
// spk_checker
// Port-level checks on the cipher engine, bound to the top level.
// ----------------------------------------------------------------------------
module spk_checker (
  input logic               clk,
  input logic               rst,
  input logic               wr_en,
  input spk_pkg::cfg_idx_t  wr_index,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input spk_pkg::word_t     result_low,
  input spk_pkg::word_t     result_high
);

  a_reset_blocks_input: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input ready high straight after reset");

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid straight after reset");

  a_key_write_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (wr_en && (wr_index == spk_pkg::REG_KEY_LOW || wr_index == spk_pkg::REG_KEY_HIGH))
    |=> !in_ready)
    else $error("input taken while round keys rebuild");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(result_low) && $stable(result_high)))
    else $error("stalled result changed or dropped");

endmodule

bind speck128_block_cipher spk_checker u_spk_checker (
  .clk         (clk),
  .rst         (rst),
  .wr_en       (wr_en),
  .wr_index    (wr_index),
  .in_ready    (blk_in.ready),
  .out_valid   (blk_out.valid),
  .out_ready   (blk_out.ready),
  .result_low  (blk_out.result_low),
  .result_high (blk_out.result_high)
);

@@ dv/speck128_block_cipher_tb.sv @@
// ----------------------------------------------------------------------------
// speck128_block_cipher_tb
// Checks the pipelined Speck128/128 engine against an in-bench predictor.
// Blocks are encrypted and decrypted under several keys, including all-zero
// and all-one keys and the published test key. The sender works in bursts and
// the receiver stalls, with two long hold-offs that back the pipeline up.
// Every result is compared, word by word, with the oldest expected result.
// ----------------------------------------------------------------------------
module speck128_block_cipher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int   CYCLE_LIMIT  = 400000;
  localparam int   SETTLE_TICKS = 40;
  localparam int   HOLD_TICKS   = 160;
  localparam spk_pkg::word_t TV_KEY_LO = 64'h0706050403020100;
  localparam spk_pkg::word_t TV_KEY_HI = 64'h0f0e0d0c0b0a0908;
  localparam spk_pkg::word_t TV_PT_LO  = 64'h7469206564616d20;
  localparam spk_pkg::word_t TV_PT_HI  = 64'h6c61766975716520;
  localparam spk_pkg::word_t TV_CT_LO  = 64'h7860fedf5c570d18;
  localparam spk_pkg::word_t TV_CT_HI  = 64'ha65d985179783265;

  typedef struct packed {
    spk_pkg::op_t   op;
    spk_pkg::word_t lo;
    spk_pkg::word_t hi;
  } blk_item_t;

  typedef struct packed {
    spk_pkg::word_t lo;
    spk_pkg::word_t hi;
  } cipher_words_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              wr_en;
  spk_pkg::cfg_idx_t wr_index;
  spk_pkg::word_t    wr_data;

  spk_in_if  in_ch ();
  spk_out_if out_ch ();

  speck128_block_cipher uut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .blk_in   (in_ch),
    .blk_out  (out_ch)
  );

  always #2 clk = ~clk;

  spk_pkg::word_t key_lo_q;
  spk_pkg::word_t key_hi_q;
  spk_pkg::word_t sched [spk_pkg::NUM_ROUNDS];
  blk_item_t      pending_q [$];
  cipher_words_t  expected_q [$];

  int accepted = 0;
  int enc_cnt = 0;
  int dec_cnt = 0;
  int checked = 0;
  int mismatches = 0;
  int key_settings = 0;
  int holds = 0;
  int cycles = 0;
  int burst_left, gap_left;
  int rx_mode, rx_span;
  int hold_left, hold_at;

  function automatic spk_pkg::word_t rotr64(spk_pkg::word_t v, int n);
    return (v >> n) | (v << (spk_pkg::WORD_W - n));
  endfunction

  function automatic spk_pkg::word_t rotl64(spk_pkg::word_t v, int n);
    return (v << n) | (v >> (spk_pkg::WORD_W - n));
  endfunction

  function automatic void round_fwd(inout spk_pkg::word_t x, inout spk_pkg::word_t y,
                                    input spk_pkg::word_t k);
    x = (rotr64(x, spk_pkg::ROT_A) + y) ^ k;
    y = rotl64(y, spk_pkg::ROT_B) ^ x;
  endfunction

  function automatic void round_inv(inout spk_pkg::word_t x, inout spk_pkg::word_t y,
                                    input spk_pkg::word_t k);
    y = rotr64(y ^ x, spk_pkg::ROT_B);
    x = rotl64((x ^ k) - y, spk_pkg::ROT_A);
  endfunction

  function automatic void rebuild_schedule();
    spk_pkg::word_t a, b;
    a = key_hi_q;
    b = key_lo_q;
    sched[0] = b;
    for (int i = 0; i + 1 < spk_pkg::NUM_ROUNDS; i++) begin
      round_fwd(a, b, spk_pkg::word_t'(i));
      sched[i+1] = b;
    end
  endfunction

  function automatic cipher_words_t predict_block(blk_item_t it);
    cipher_words_t r;
    spk_pkg::word_t x, y;
    x = it.hi;
    y = it.lo;
    if (it.op == spk_pkg::OP_ENC) begin
      for (int i = 0; i < spk_pkg::NUM_ROUNDS; i++) round_fwd(x, y, sched[i]);
    end else begin
      for (int i = spk_pkg::NUM_ROUNDS - 1; i >= 0; i--) round_inv(x, y, sched[i]);
    end
    r.lo = y;
    r.hi = x;
    return r;
  endfunction

  function automatic spk_pkg::word_t rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return spk_pkg::word_t'(1) << $urandom_range(0, spk_pkg::WORD_W - 1);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic void queue_block(spk_pkg::op_t op, spk_pkg::word_t lo,
                                      spk_pkg::word_t hi);
    blk_item_t it;
    it.op = op;
    it.lo = lo;
    it.hi = hi;
    pending_q.push_back(it);
  endfunction

  function automatic void queue_random(int n);
    for (int i = 0; i < n; i++)
      queue_block(spk_pkg::op_t'($urandom_range(0, 1)), rand_word(), rand_word());
  endfunction

  function automatic void report_mismatch(string what, spk_pkg::word_t want,
                                          spk_pkg::word_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %h got %h at %0t", what, want, got, $realtime);
  endfunction

  task automatic settle();
    while (pending_q.size() != 0 || expected_q.size() != 0 || in_ch.valid)
      @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_key(spk_pkg::cfg_idx_t idx, spk_pkg::word_t val);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    if (idx == spk_pkg::REG_KEY_LOW) begin
      key_lo_q = val;
      rebuild_schedule();
    end else if (idx == spk_pkg::REG_KEY_HIGH) begin
      key_hi_q = val;
      rebuild_schedule();
    end
    @(posedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic new_key_phase(spk_pkg::word_t lo, spk_pkg::word_t hi, int n);
    settle();
    write_key(spk_pkg::REG_KEY_LOW, lo);
    write_key(spk_pkg::REG_KEY_HIGH, hi);
    key_settings++;
    queue_random(n);
  endtask

  // sender: bursts of items with random gaps, hold the item until taken
  always @(posedge clk) begin : tx_drive
    blk_item_t sent;
    if (rst) begin
      in_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        sent = pending_q.pop_front();
        expected_q.push_back(predict_block(sent));
        if (sent.op == spk_pkg::OP_ENC) enc_cnt <= enc_cnt + 1;
        else dec_cnt <= dec_cnt + 1;
        accepted <= accepted + 1;
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (gap_left != 0 || pending_q.size() == 0) begin
          if (gap_left != 0) gap_left--;
          in_ch.valid <= 1'b0;
        end else begin
          if (burst_left == 0) burst_left = $urandom_range(1, 48);
          in_ch.valid      <= 1'b1;
          in_ch.op         <= pending_q[0].op;
          in_ch.block_low  <= pending_q[0].lo;
          in_ch.block_high <= pending_q[0].hi;
          burst_left--;
          if (burst_left == 0)
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
  end

  // long receiver hold-off, twice in the random part
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_at   <= 400;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (accepted >= hold_at) begin
      hold_left <= HOLD_TICKS;
      hold_at   <= hold_at + 800;
      holds     <= holds + 1;
    end
  end

  // receiver: check each result, stall on its own pattern
  always @(posedge clk) begin : rx_check
    cipher_words_t want;
    logic go;
    if (rst) begin
      out_ch.ready <= 1'b0;
      rx_mode = 0;
      rx_span = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        checked++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result_low", '0, out_ch.result_low);
        end else begin
          want = expected_q.pop_front();
          if (out_ch.result_low !== want.lo)
            report_mismatch("result_low", want.lo, out_ch.result_low);
          if (out_ch.result_high !== want.hi)
            report_mismatch("result_high", want.hi, out_ch.result_high);
        end
      end
      if (rx_span == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_span = $urandom_range(16, 160);
      end else begin
        rx_span--;
      end
      case (rx_mode)
        0: go = 1'b1;
        1: go = $urandom_range(0, 1);
        default: go = ($urandom_range(0, 3) == 0);
      endcase
      out_ch.ready <= go && (hold_left == 0);
    end
  end

  always @(posedge clk) cycles <= cycles + 1;

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding", cycles, expected_q.size());
    $display("speck128_block_cipher_tb NOT OK");
    $finish;
  end

  initial begin
    rst              = 1'b1;
    wr_en            = 1'b0;
    wr_index         = spk_pkg::REG_KEY_LOW;
    wr_data          = '0;
    in_ch.valid      = 1'b0;
    in_ch.op         = spk_pkg::OP_ENC;
    in_ch.block_low  = '0;
    in_ch.block_high = '0;
    out_ch.ready     = 1'b0;
    key_lo_q         = '0;
    key_hi_q         = '0;
    rebuild_schedule();
    key_settings = 1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // all-zero key from reset, extreme and patterned blocks
    queue_block(spk_pkg::OP_ENC, '0, '0);
    queue_block(spk_pkg::OP_DEC, '0, '0);
    queue_block(spk_pkg::OP_ENC, '1, '1);
    queue_block(spk_pkg::OP_DEC, '1, '1);
    queue_block(spk_pkg::OP_ENC, '1, '0);
    queue_block(spk_pkg::OP_DEC, '0, '1);
    queue_block(spk_pkg::OP_ENC, {32{2'b01}}, {32{2'b10}});
    queue_block(spk_pkg::OP_DEC, {32{2'b10}}, {32{2'b01}});
    queue_block(spk_pkg::OP_ENC, spk_pkg::word_t'(1),
                spk_pkg::word_t'(1) << (spk_pkg::WORD_W - 1));

    // published test key and vector, both directions
    settle();
    write_key(spk_pkg::REG_KEY_LOW, TV_KEY_LO);
    write_key(spk_pkg::REG_KEY_HIGH, TV_KEY_HI);
    key_settings++;
    queue_block(spk_pkg::OP_ENC, TV_PT_LO, TV_PT_HI);
    queue_block(spk_pkg::OP_DEC, TV_CT_LO, TV_CT_HI);
    queue_block(spk_pkg::OP_ENC, TV_CT_LO, TV_CT_HI);
    queue_block(spk_pkg::OP_DEC, TV_PT_LO, TV_PT_HI);

    // writes to unused indexes leave the key alone
    settle();
    write_key(spk_pkg::cfg_idx_t'(2), rand_word());
    write_key('1, rand_word());
    queue_block(spk_pkg::OP_ENC, TV_PT_LO, TV_PT_HI);
    queue_block(spk_pkg::OP_DEC, TV_CT_LO, TV_CT_HI);
    queue_random(275);

    new_key_phase('0, '1, 275);
    new_key_phase('1, '0, 275);

    // change one key word only
    settle();
    write_key(spk_pkg::REG_KEY_HIGH, '1);
    key_settings++;
    queue_random(275);

    new_key_phase({$urandom, $urandom}, {$urandom, $urandom}, 275);

    settle();
    write_key(spk_pkg::REG_KEY_LOW, {$urandom, $urandom});
    key_settings++;
    queue_random(275);

    settle();
    $display("covered %0d blocks (%0d encrypt, %0d decrypt) under %0d key settings",
             accepted, enc_cnt, dec_cnt, key_settings);
    $display("%0d results checked, %0d receiver hold-offs, %0d mismatches",
             checked, holds, mismatches);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("speck128_block_cipher_tb OK");
    end else begin
      $display("speck128_block_cipher_tb NOT OK");
    end
    $finish;
  end

endmodule
